// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level of the ring allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define VLRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define VLRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/vlra_pkg.sv =====
// constants, codes and types of the ring allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vlra_pkg;
    localparam int NUM_SLOTS    = 256;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int RING_W       = $clog2(NUM_SLOTS + 1);
    localparam int ID_W         = 20;
    localparam int LEN_W        = 24;
    localparam int HEADER_BYTES = 12;
    localparam int ITER_MAX     = 4 * NUM_SLOTS + 8;
    localparam int ITER_W       = $clog2(ITER_MAX + 2);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_BLOCKED  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [1:0] CFG_BUFFER_BYTES = 2'd0;
    localparam logic [1:0] CFG_SLOTS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_BLOCKING     = 2'd2;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  entry_len;
    } t_slot_wr;

    typedef struct packed {
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] entry_len;
    } t_slot_rd;
endpackage
`default_nettype wire

// ===== rtl/vlra_req_if.sv =====
// request channel of the ring allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface vlra_req_if;
    logic                      valid;
    logic                      ready;
    logic [23:0]               payload_bytes;
    logic [23:0]               recorded_bytes;
    logic signed [31:0]        kind;
    logic signed [31:0]        subkind;
    logic signed [20:0]        reader_last_id;

    modport source (output valid, payload_bytes, recorded_bytes, kind, subkind,
                    reader_last_id, input ready);
    modport sink (input valid, payload_bytes, recorded_bytes, kind, subkind,
                  reader_last_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/vlra_rsp_if.sv =====
// result channel of the ring allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface vlra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [19:0] message_id;
    logic [23:0] byte_offset;
    logic [23:0] entry_bytes;
    logic [8:0]  freed_count;

    modport source (output valid, status, slot_index, message_id, byte_offset,
                    entry_bytes, freed_count, input ready);
    modport sink (input valid, status, slot_index, message_id, byte_offset,
                  entry_bytes, freed_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/vlra_slot_mem.sv =====
// slot table: offset and entry length of each ring slot
// depends on vlra_pkg
`timescale 1ns / 1ps
`default_nettype none
module vlra_slot_mem (
    input  wire                          i_clk,
    input  wire vlra_pkg::t_slot_wr      i_wr,
    input  wire [vlra_pkg::SLOT_W-1:0]   i_rd_addr,
    output vlra_pkg::t_slot_rd           o_rd
);
    import vlra_pkg::*;

    t_slot_rd r_mem [NUM_SLOTS];
    t_slot_rd r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= '{offset: i_wr.offset, entry_len: i_wr.entry_len};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd = r_rd;
endmodule
`default_nettype wire

// ===== rtl/variable_length_ring_allocator.sv =====
// top level of the variable length ring allocator
// depends on vlra_pkg, vlra_req_if, vlra_rsp_if, vlra_slot_mem, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
// Without freeing, an item passes acceptance, the checks and the fit test.
// Freeing the slot about to be reused adds a table read and a free step, each
// further oldest slot freed to make room adds both and a fit test, and a
// switch from append to insert mode adds a fit test; freeing is paced by the
// registered read port of the slot table. The block takes no new item until
// the current one is finished. Refused items (blocked, too large) end after
// the checks and change nothing. The result waits in an output register; while
// an earlier result is still untaken the block holds in its last step.
module variable_length_ring_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vlra_req_if.sink   i_req,
    vlra_rsp_if.source o_rsp,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [23:0] i_cfg_data
);
    import vlra_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FDO  = 3'd3;
    localparam logic [2:0] S_FIT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_buf_bytes;
    logic [8:0]        r_slots;
    logic              r_blocking;

    logic [SLOT_W-1:0] r_newest, n_newest, r_oldest, n_oldest;
    logic              r_oldest_valid, n_oldest_valid;
    logic [ID_W-1:0]   r_newest_id, n_newest_id;
    logic [LEN_W-1:0]  r_app_start, n_app_start, r_ins_start, n_ins_start;
    logic [LEN_W-1:0]  r_ins_end, n_ins_end;
    logic              r_app_mode, n_app_mode;

    logic [LEN_W:0]    r_entry, n_entry;
    logic [20:0]       r_last, n_last;
    logic [8:0]        r_freed, n_freed;
    logic [ITER_W-1:0] r_iter, n_iter;

    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostatus, n_ostatus;
    logic [7:0]        r_oslot, n_oslot;
    logic [19:0]       r_oid, n_oid;
    logic [23:0]       r_ooff, n_ooff;
    logic [23:0]       r_olen, n_olen;
    logic [8:0]        r_ofreed, n_ofreed;

    t_slot_wr          slot_wr;
    t_slot_rd          slot_rd;

    logic              out_free;
    logic [RING_W-1:0] ring_len;
    logic [SLOT_W-1:0] ws, oldest_next;
    logic [ID_W-1:0]   wid, ov_id;
    logic [LEN_W:0]    fit_lhs, fit_rhs, free_end;
    logic              do_clear;

    vlra_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_addr (r_oldest),
        .o_rd      (slot_rd)
    );

    assign out_free = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        if (r_slots == 9'd0) begin
            ring_len = RING_W'(1);
        end else if (r_slots > 9'(NUM_SLOTS)) begin
            ring_len = RING_W'(NUM_SLOTS);
        end else begin
            ring_len = RING_W'(r_slots);
        end
        ws = ((RING_W'(r_newest) + RING_W'(1)) >= ring_len) ? '0 : r_newest + 1'b1;
        oldest_next = ((RING_W'(r_oldest) + RING_W'(1)) >= ring_len) ? '0
                    : r_oldest + 1'b1;
        wid   = r_newest_id + 1'b1;
        ov_id = wid - ID_W'(ring_len);
        // shared add and compare: fit test in append or insert region
        fit_lhs  = r_app_mode ? {1'b0, r_buf_bytes} : {1'b0, r_ins_end};
        fit_rhs  = (r_app_mode ? {1'b0, r_app_start} : {1'b0, r_ins_start}) + r_entry;
        free_end = {1'b0, r_ins_end} + {1'b0, slot_rd.entry_len};
    end

    always_comb begin
        n_state        = r_state;
        n_newest       = r_newest;
        n_oldest       = r_oldest;
        n_oldest_valid = r_oldest_valid;
        n_newest_id    = r_newest_id;
        n_app_start    = r_app_start;
        n_ins_start    = r_ins_start;
        n_ins_end      = r_ins_end;
        n_app_mode     = r_app_mode;
        n_entry        = r_entry;
        n_last         = r_last;
        n_freed        = r_freed;
        n_iter         = r_iter;
        n_ovalid       = r_ovalid && !o_rsp.ready;
        n_ostatus      = r_ostatus;
        n_oslot        = r_oslot;
        n_oid          = r_oid;
        n_ooff         = r_ooff;
        n_olen         = r_olen;
        n_ofreed       = r_ofreed;
        slot_wr        = '0;
        do_clear       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_entry = (({1'b0, i_req.payload_bytes} + 25'd3) & ~25'd3)
                            + 25'(HEADER_BYTES);
                    n_last  = i_req.reader_last_id;
                    n_freed = '0;
                    n_iter  = '0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_blocking && !r_last[20] && (r_last[19:0] == ov_id)) begin
                    if (out_free) begin
                        n_ovalid = 1'b1; n_ostatus = ST_BLOCKED; n_oslot = '0;
                        n_oid = '0; n_ooff = '0; n_olen = '0; n_ofreed = '0;
                        n_state = S_IDLE;
                    end
                end else if (r_entry > {1'b0, r_buf_bytes}) begin
                    if (out_free) begin
                        n_ovalid = 1'b1; n_ostatus = ST_TOO_BIG; n_oslot = '0;
                        n_oid = '0; n_ooff = '0; n_olen = '0; n_ofreed = '0;
                        n_state = S_IDLE;
                    end
                end else if (r_oldest_valid && (ws == r_oldest)) begin
                    n_state = S_FRD;
                end else begin
                    n_state = S_FIT;
                end
            end
            S_FRD: begin
                n_state = S_FDO;
            end
            S_FDO: begin
                if (!r_oldest_valid || (slot_rd.offset != r_ins_end)) begin
                    if (out_free) begin
                        do_clear = 1'b1;
                        n_ovalid = 1'b1; n_ostatus = ST_MISMATCH; n_oslot = '0;
                        n_oid = '0; n_ooff = '0; n_olen = '0; n_ofreed = r_freed;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (free_end >= {1'b0, r_app_start}) begin
                        n_app_start = r_ins_start;
                        n_ins_start = '0;
                        n_ins_end   = '0;
                        n_app_mode  = 1'b1;
                    end else begin
                        n_ins_end = free_end[LEN_W-1:0];
                    end
                    if (r_oldest == r_newest) begin
                        n_oldest_valid = 1'b0;
                    end
                    n_oldest = oldest_next;
                    n_freed  = r_freed + 1'b1;
                    n_state  = S_FIT;
                end
            end
            S_FIT: begin
                if (r_iter > ITER_W'(ITER_MAX)) begin
                    if (out_free) begin
                        do_clear = 1'b1;
                        n_ovalid = 1'b1; n_ostatus = ST_MISMATCH; n_oslot = '0;
                        n_oid = '0; n_ooff = '0; n_olen = '0; n_ofreed = r_freed;
                        n_state = S_IDLE;
                    end
                end else if (fit_lhs >= fit_rhs) begin
                    if (out_free) begin
                        slot_wr.en        = 1'b1;
                        slot_wr.addr      = ws;
                        slot_wr.offset    = r_app_mode ? r_app_start : r_ins_start;
                        slot_wr.entry_len = r_entry[LEN_W-1:0];
                        n_newest = ws;
                        if (!r_oldest_valid) begin
                            n_oldest       = ws;
                            n_oldest_valid = 1'b1;
                        end
                        if (r_app_mode) begin
                            n_app_start = fit_rhs[LEN_W-1:0];
                        end else begin
                            n_ins_start = fit_rhs[LEN_W-1:0];
                        end
                        n_newest_id = wid;
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_OK;
                        n_oslot   = 8'(ws);
                        n_oid     = wid;
                        n_ooff    = slot_wr.offset;
                        n_olen    = r_entry[LEN_W-1:0];
                        n_ofreed  = r_freed;
                        n_state   = S_IDLE;
                    end
                end else if (r_app_mode) begin
                    n_app_mode = 1'b0;
                    n_iter     = r_iter + 1'b1;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = S_FRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_clear) begin
            n_newest       = SLOT_W'(NUM_SLOTS - 1);
            n_oldest       = '0;
            n_oldest_valid = 1'b0;
            n_newest_id    = '1;
            n_app_start    = '0;
            n_ins_start    = '0;
            n_ins_end      = '0;
            n_app_mode     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_buf_bytes    <= 24'd1048576;
            r_slots        <= 9'(NUM_SLOTS);
            r_blocking     <= 1'b0;
            r_newest       <= SLOT_W'(NUM_SLOTS - 1);
            r_oldest       <= '0;
            r_oldest_valid <= 1'b0;
            r_newest_id    <= '1;
            r_app_start    <= '0;
            r_ins_start    <= '0;
            r_ins_end      <= '0;
            r_app_mode     <= 1'b1;
            r_ovalid       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_newest       <= n_newest;
            r_oldest       <= n_oldest;
            r_oldest_valid <= n_oldest_valid;
            r_newest_id    <= n_newest_id;
            r_app_start    <= n_app_start;
            r_ins_start    <= n_ins_start;
            r_ins_end      <= n_ins_end;
            r_app_mode     <= n_app_mode;
            r_ovalid       <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_BYTES: r_buf_bytes <= i_cfg_data;
                    CFG_SLOTS_IN_USE: r_slots     <= i_cfg_data[8:0];
                    CFG_BLOCKING:     r_blocking  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry   <= n_entry;
        r_last    <= n_last;
        r_freed   <= n_freed;
        r_iter    <= n_iter;
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
        r_oid     <= n_oid;
        r_ooff    <= n_ooff;
        r_olen    <= n_olen;
        r_ofreed  <= n_ofreed;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.slot_index  = r_oslot;
    assign o_rsp.message_id  = r_oid;
    assign o_rsp.byte_offset = r_ooff;
    assign o_rsp.entry_bytes = r_olen;
    assign o_rsp.freed_count = r_ofreed;

    `VLRA_ASSERT(a_accept_to_pre, (i_req.valid && i_req.ready) |=> (r_state == S_PRE), "accepted item did not start")
    `VLRA_ASSERT(a_result_from_work, $rose(o_rsp.valid) |-> ($past(r_state) != S_IDLE), "result without work")
    `VLRA_ASSERT(a_runaway_clears, (r_state == S_FIT && r_iter > ITER_W'(ITER_MAX) && out_free) |=> (r_app_mode && !r_oldest_valid && r_state == S_IDLE), "runaway search did not clear")
    `VLRA_ASSERT(a_read_before_free, (r_state == S_FDO) |-> ($past(r_state) == S_FRD || $past(r_state) == S_FDO), "free without table read")
endmodule
`default_nettype wire

// ===== tb/sv/vlra_checker.sv =====
// result checker of the ring allocator: watches the request, result and register ports
// keeps its own copy of the slot ring and the byte buffer, depends on vlra_pkg and the channels
`timescale 1ns / 1ps
module vlra_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vlra_req_if         req,
    vlra_rsp_if         rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output logic [19:0] o_overwritten_id,
    output int          o_status_count [4]
);
    import vlra_pkg::*;

    localparam int unsigned ID_MOD = 1 << ID_W;
    localparam int unsigned MASK24 = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [19:0] id;
        logic [23:0] offset;
        logic [23:0] entry;
        logic [8:0]  freed;
    } t_alloc_result;

    t_alloc_result awaited_allocs[$];

    int unsigned slot_off [NUM_SLOTS];
    int unsigned slot_len [NUM_SLOTS];
    int unsigned newest_slot, tail_slot, newest_id;
    int unsigned append_start, insert_start, insert_end;
    bit          oldest_valid, in_append;
    int unsigned buf_cap, ring_cfg;
    bit          blocking;

    function automatic int unsigned ring_len();
        int unsigned n;
        n = ring_cfg;
        if (n < 1) n = 1;
        if (n > NUM_SLOTS) n = NUM_SLOTS;
        return n;
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= ring_len()) ? 0 : s + 1;
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_off[i] = 0;
            slot_len[i] = 0;
        end
        newest_slot  = NUM_SLOTS - 1;
        tail_slot    = 0;
        oldest_valid = 0;
        newest_id    = ID_MOD - 1;
        append_start = 0;
        insert_start = 0;
        insert_end   = 0;
        in_append    = 1;
    endfunction

    // returns 1 when the ring was found inconsistent and cleared
    function automatic bit free_oldest();
        int unsigned s;
        longint unsigned end_pos;
        s = tail_slot;
        if (s >= NUM_SLOTS || !oldest_valid || slot_off[s] != insert_end) begin
            clear_ring();
            return 1;
        end
        end_pos = longint'(insert_end) + longint'(slot_len[s]);
        if (end_pos >= longint'(append_start)) begin
            append_start = insert_start;
            insert_start = 0;
            end_pos      = 0;
            in_append    = 1;
        end
        insert_end = int'(end_pos) & MASK24;
        if (s == newest_slot) oldest_valid = 0;
        tail_slot = next_slot(s);
        return 0;
    endfunction

    function automatic t_alloc_result predict_allocation(int unsigned payload,
                                                         logic signed [20:0] reader_id);
        t_alloc_result r;
        int unsigned   ns, ws, wid, entry, ov, freed, iter, off;
        r     = '0;
        freed = 0;
        iter  = 0;
        ns    = ring_len();
        ws    = next_slot(newest_slot);
        wid   = (newest_id + 1) % ID_MOD;
        entry = ((payload + 3) & ~32'd3) + HEADER_BYTES;
        if (blocking) begin
            ov = (wid + ID_MOD - ns % ID_MOD) % ID_MOD;
            if (int'(reader_id) >= 0 && int'(reader_id) == int'(ov)) begin
                r.status = ST_BLOCKED;
                return r;
            end
        end
        if (entry > buf_cap) begin
            r.status = ST_TOO_BIG;
            return r;
        end
        if (oldest_valid && ws == tail_slot) begin
            if (free_oldest()) begin
                r.status = ST_MISMATCH;
                return r;
            end
            freed++;
        end
        while (1) begin
            if (iter > ITER_MAX) begin
                clear_ring();
                r.status = ST_MISMATCH;
                r.freed  = freed[8:0];
                return r;
            end
            if (in_append) begin
                if (longint'(buf_cap) - longint'(append_start) >= longint'(entry)) break;
                in_append = 0;
            end else begin
                if (longint'(insert_end) - longint'(insert_start) >= longint'(entry)) break;
                if (free_oldest()) begin
                    r.status = ST_MISMATCH;
                    r.freed  = freed[8:0];
                    return r;
                end
                freed++;
            end
            iter++;
        end
        off = in_append ? append_start : insert_start;
        if (ws < NUM_SLOTS) begin
            slot_off[ws] = off;
            slot_len[ws] = entry & MASK24;
        end
        newest_slot = ws;
        if (!oldest_valid) begin
            tail_slot    = ws;
            oldest_valid = 1;
        end
        if (in_append) append_start = (append_start + entry) & MASK24;
        else insert_start = (insert_start + entry) & MASK24;
        newest_id = wid;
        r.status = ST_OK;
        r.slot   = ws[7:0];
        r.id     = wid[19:0];
        r.offset = off[23:0];
        r.entry  = entry[23:0];
        r.freed  = freed[8:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors = 0;
        for (int i = 0; i < 4; i++) o_status_count[i] = 0;
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            buf_cap  = 1048576;
            ring_cfg = NUM_SLOTS;
            blocking = 0;
            clear_ring();
            awaited_allocs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_BYTES: buf_cap  = 32'(i_cfg_data);
                    CFG_SLOTS_IN_USE: ring_cfg = 32'(i_cfg_data[8:0]);
                    CFG_BLOCKING:     blocking = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                o_status_count[rsp.status]++;
                if (awaited_allocs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, rsp.status);
                    o_errors++;
                end else begin
                    want = awaited_allocs.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("slot_index", 32'(want.slot), 32'(rsp.slot_index));
                    check_field("message_id", 32'(want.id), 32'(rsp.message_id));
                    check_field("byte_offset", 32'(want.offset), 32'(rsp.byte_offset));
                    check_field("entry_bytes", 32'(want.entry), 32'(rsp.entry_bytes));
                    check_field("freed_count", 32'(want.freed), 32'(rsp.freed_count));
                end
            end
            if (req.valid && req.ready)
                awaited_allocs.push_back(predict_allocation(32'(req.payload_bytes),
                                                            req.reader_last_id));
        end
        o_pending        = awaited_allocs.size();
        o_overwritten_id = 20'((newest_id + 1 + ID_MOD - ring_len() % ID_MOD) % ID_MOD);
    end
endmodule

// ===== tb/sv/testbench.sv =====
// top of the ring allocator bench: clock, reset, register writes and request items
// depends on vlra_pkg, the request and result channels, vlra_checker and the block
`timescale 1ns / 1ps
module testbench;
    import vlra_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    vlra_req_if req ();
    vlra_rsp_if rsp ();

    int          errors, pending, status_count [4];
    logic [19:0] overwritten_id;
    int          idle_pct, stall_pct, cycles, items;
    int unsigned cur_buf;

    variable_length_ring_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    vlra_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .req              (req),
        .rsp              (rsp),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_overwritten_id (overwritten_id),
        .o_status_count   (status_count)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(negedge i_clk) rsp.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic [23:0] payload, logic [23:0] recorded,
                             logic [31:0] kind, logic [31:0] subkind,
                             logic signed [20:0] reader);
        while ($urandom_range(99) < idle_pct) begin
            req.valid <= 0;
            @(negedge i_clk);
        end
        req.valid          <= 1;
        req.payload_bytes  <= payload;
        req.recorded_bytes <= recorded;
        req.kind           <= kind;
        req.subkind        <= subkind;
        req.reader_last_id <= reader;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int unsigned        pick;
        logic [23:0]        payload;
        logic signed [20:0] reader;
        pick = $urandom_range(99);
        if (pick < 8) payload = 0;
        else if (pick < 14) payload = 24'($urandom);
        else if (pick < 20) payload = 24'(cur_buf - $urandom_range(15));
        else payload = 24'($urandom_range(cur_buf / 5 + 4));
        if (payload > 24'd16777203) payload = 24'd16777203;
        pick = $urandom_range(99);
        if (pick < 40) reader = {1'b0, overwritten_id};
        else if (pick < 50) reader = -21'sd1;
        else reader = 21'($urandom_range(1048576) - 1);
        send_item(payload, 24'($urandom), $urandom, $urandom, reader);
    endtask

    initial begin
        int unsigned bufs   [6] = '{4096, 16777215, 600, 16, 300, 200};
        int unsigned rings  [6] = '{256, 200, 64, 16, 3, 1};
        int unsigned blocks [6] = '{0, 1, 1, 0, 1, 0};
        int unsigned idles  [6] = '{0, 85, 0, 36, 0, 36};
        int unsigned stalls [6] = '{0, 0, 85, 36, 0, 36};
        i_rst_n            = 0;
        i_cfg_we           = 0;
        i_cfg_idx          = CFG_BUFFER_BYTES;
        i_cfg_data         = 0;
        req.valid          = 0;
        req.payload_bytes  = 0;
        req.recorded_bytes = 0;
        req.kind           = 0;
        req.subkind        = 0;
        req.reader_last_id = 0;
        rsp.ready          = 0;
        idle_pct           = 0;
        stall_pct          = 0;
        cycles             = 0;
        items              = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: field extremes, padding, too large, blocked
        cur_buf = 1048576;
        write_reg(CFG_BUFFER_BYTES, 24'(cur_buf));
        write_reg(CFG_SLOTS_IN_USE, 24'(NUM_SLOTS));
        write_reg(CFG_BLOCKING, 0);
        for (int p = 0; p < 9; p++)
            send_item(24'(p), 24'(p % 2) * 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      -21'sd1);
        send_item(24'd16777203, 0, 32'h7FFF_FFFF, 32'h8000_0000, 21'sd1048575);
        send_item(24'd1048564, 0, 0, 0, 0);
        drain();
        write_reg(CFG_BLOCKING, 1);
        send_item(4, 1, 2, 3, {1'b0, overwritten_id});
        send_item(4, 1, 2, 3, -21'sd1);
        send_item(4, 1, 2, 3, 21'sd1048575);
        drain();
        cur_buf = 16777215;
        write_reg(CFG_BUFFER_BYTES, 24'(cur_buf));
        send_item(24'd16777203, 24'hFFFFFF, -1, -1, -21'sd1);
        send_item(0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            cur_buf = bufs[ph];
            write_reg(CFG_BUFFER_BYTES, 24'(cur_buf));
            write_reg(CFG_SLOTS_IN_USE, 24'(rings[ph]));
            write_reg(CFG_BLOCKING, 24'(blocks[ph]));
            idle_pct  = idles[ph];
            stall_pct = stalls[ph];
            for (int n = 0; n < 130; n++) begin
                if (ph == 2 && n == 60) drain();
                random_item();
            end
            drain();
        end

        stall_pct = 0;
        repeat (20) @(negedge i_clk);
        $display("%0d items sent over six register settings: %0d placed, %0d too large,",
                 items, status_count[ST_OK], status_count[ST_TOO_BIG]);
        $display("%0d blocked, %0d ring resets", status_count[ST_BLOCKED],
                 status_count[ST_MISMATCH]);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
